[rtl/core/smx_pkg.sv]
// stack machine execute unit: shared types and codes
// used by smx_iter and stack_machine_execute_unit; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package smx_pkg;

  typedef enum logic [3:0] {
    K_PUSH  = 4'd0,
    K_OUT   = 4'd1,
    K_ADD   = 4'd2,
    K_SUB   = 4'd3,
    K_MUL   = 4'd4,
    K_DIV   = 4'd5,
    K_SQRT  = 4'd6,
    K_PUSHR = 4'd7,
    K_POPR  = 4'd8,
    K_JMP   = 4'd9,
    K_JCOND = 4'd10,
    K_CALL  = 4'd11,
    K_RET   = 4'd12,
    K_PUSHM = 4'd13,
    K_POPM  = 4'd14
  } kind_t;

  typedef enum logic [2:0] {
    C_LT = 3'd0,
    C_LE = 3'd1,
    C_GT = 3'd2,
    C_GE = 3'd3,
    C_EQ = 3'd4,
    C_NE = 3'd5
  } cond_t;

  localparam logic [2:0] ERR_OK      = 3'd0;
  localparam logic [2:0] ERR_UNDER   = 3'd1;
  localparam logic [2:0] ERR_OVER    = 3'd2;
  localparam logic [2:0] ERR_DIVZERO = 3'd3;
  localparam logic [2:0] ERR_SQRTNEG = 3'd4;
  localparam logic [2:0] ERR_BADREG  = 3'd5;
  localparam logic [2:0] ERR_RAM     = 3'd6;
  localparam logic [2:0] ERR_VRAM    = 3'd7;

  typedef enum logic [1:0] {
    IT_MUL  = 2'd0,
    IT_DIV  = 2'd1,
    IT_SQRT = 2'd2
  } iter_op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_EXEC,
    ST_ITER,
    ST_RESP
  } state_t;

endpackage

`default_nettype wire

[rtl/core/smx_ram.sv]
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module smx_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/core/smx_iter.sv]
// radix-2 iterative unit: 64-bit multiply, signed truncating divide, floor sqrt
// depends on smx_pkg
`timescale 1ns / 1ps
`default_nettype none

module smx_iter (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire smx_pkg::iter_op_t  op,
  input  wire logic [63:0]        a,
  input  wire logic [63:0]        b,
  output logic                    done,
  output logic [63:0]             result
);
  import smx_pkg::*;

  logic        busy_r, busy_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  iter_op_t    op_r, op_nxt;
  logic        neg_r, neg_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] x_r, x_nxt;
  logic [63:0] y_r, y_nxt;
  logic [65:0] rem_r, rem_nxt;
  logic [64:0] r2d;
  logic [65:0] r2s;
  logic [65:0] trial;

  assign done   = busy_r && (cnt_r == 7'd0);
  assign result = (op_r == IT_DIV) ? (neg_r ? (64'd0 - x_r) : x_r) : acc_r;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    op_nxt   = op_r;
    neg_nxt  = neg_r;
    acc_nxt  = acc_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    rem_nxt  = rem_r;
    r2d      = {rem_r[63:0], x_r[63]};
    r2s      = {rem_r[63:0], x_r[63:62]};
    trial    = {acc_r, 2'b01};
    if (start) begin
      busy_nxt = 1'b1;
      op_nxt   = op;
      acc_nxt  = 64'd0;
      rem_nxt  = 66'd0;
      neg_nxt  = 1'b0;
      x_nxt    = a;
      y_nxt    = b;
      cnt_nxt  = 7'd63;
      case (op)
        IT_DIV: begin
          x_nxt   = b[63] ? (64'd0 - b) : b;
          y_nxt   = a[63] ? (64'd0 - a) : a;
          neg_nxt = a[63] ^ b[63];
        end
        IT_SQRT: begin
          cnt_nxt = 7'd31;
        end
        default: begin
        end
      endcase
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd0) begin
        busy_nxt = 1'b0;
      end
      case (op_r)
        IT_MUL: begin
          if (x_r[0]) begin
            acc_nxt = acc_r + y_r;
          end
          x_nxt = {1'b0, x_r[63:1]};
          y_nxt = {y_r[62:0], 1'b0};
        end
        IT_DIV: begin
          if (r2d >= {1'b0, y_r}) begin
            rem_nxt = {1'b0, r2d - {1'b0, y_r}};
            x_nxt   = {x_r[62:0], 1'b1};
          end else begin
            rem_nxt = {1'b0, r2d};
            x_nxt   = {x_r[62:0], 1'b0};
          end
        end
        IT_SQRT: begin
          x_nxt = {x_r[61:0], 2'b00};
          if (r2s >= trial) begin
            rem_nxt = r2s - trial;
            acc_nxt = {acc_r[62:0], 1'b1};
          end else begin
            rem_nxt = r2s;
            acc_nxt = {acc_r[62:0], 1'b0};
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 7'd0;
      op_r   <= IT_MUL;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      op_r   <= op_nxt;
    end
    neg_r <= neg_nxt;
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    rem_r <= rem_nxt;
  end

endmodule

`default_nettype wire

[rtl/core/stack_machine_execute_unit.sv]
// stack machine execute unit: top level, sequencer and state memories
// depends on smx_pkg, smx_ram, smx_iter
`timescale 1ns / 1ps
`default_nettype none

// Executes one instruction per input transaction and returns one result transaction.
// The data stack, return stack, RAM and VRAM live in synchronous memories; the
// sequencer reads the top two stack entries one after the other through the single
// read port, executes, then writes back as the result is registered. Mul, div and sqrt
// run in the shared radix-2 iterative unit. After reset the block clears every word of
// RAM and VRAM before in_tready rises.
module stack_machine_execute_unit #(
  parameter int STACK_DEPTH  = 64,
  parameter int RETURN_DEPTH = 32,
  parameter int NUM_REGS     = 8,
  parameter int RAM_WORDS    = 1024,
  parameter int VRAM_WORDS   = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,   // operand[63:0], condition[66:64], zero pad
  input  wire logic [4:0]  in_tuser,   // kind[3:0], mem_select[4]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [87:0]      out_tdata,  // next_ip[15:0], out_value[79:16], error_code[82:80]
  output logic             out_tuser   // out_valid
);
  import smx_pkg::*;

  localparam int SW   = $clog2(STACK_DEPTH);
  localparam int DW   = $clog2(STACK_DEPTH + 1);
  localparam int RSW  = (RETURN_DEPTH > 1) ? $clog2(RETURN_DEPTH) : 1;
  localparam int RDW  = $clog2(RETURN_DEPTH + 1);
  localparam int RIW  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int RAW  = (RAM_WORDS > 1) ? $clog2(RAM_WORDS) : 1;
  localparam int VAW  = (VRAM_WORDS > 1) ? $clog2(VRAM_WORDS) : 1;
  localparam int MEMW = (RAM_WORDS > VRAM_WORDS) ? RAM_WORDS : VRAM_WORDS;
  localparam int CLW  = $clog2(MEMW + 1);

  state_t          state_r, state_nxt;
  logic [15:0]     ip_r, ip_nxt;
  logic [DW-1:0]   dd_r, dd_nxt;
  logic [RDW-1:0]  rd_r, rd_nxt;
  logic [CLW-1:0]  clr_r;
  kind_t           kind_r;
  logic [63:0]     opnd_r;
  logic [2:0]      cond_r;
  logic            msel_r;
  logic [63:0]     a_r, b_r, mem_r;
  logic [15:0]     ret_r;
  logic [63:0]     regs_r [NUM_REGS];

  logic            ovalid_r;
  logic [15:0]     onip_r;
  logic            oov_r;
  logic [63:0]     oval_r;
  logic [2:0]      oerr_r;

  logic            commit;
  logic [15:0]     nip;
  logic [2:0]      err;
  logic            ov;
  logic [63:0]     oval;

  logic            ds_we;
  logic [SW-1:0]   ds_waddr, ds_raddr;
  logic [63:0]     ds_wdata, ds_rdata;
  logic [DW-1:0]   dd_m1, dd_m2;
  logic            rs_we;
  logic [RDW-1:0]  rd_m1;
  logic [15:0]     rs_rdata;
  logic            ram_we, vram_we;
  logic [RAW-1:0]  ram_waddr;
  logic [VAW-1:0]  vram_waddr;
  logic [63:0]     ram_wdata, vram_wdata, ram_rdata, vram_rdata;
  logic            reg_we;

  logic [RIW-1:0]  ridx;
  logic            badreg;
  logic [63:0]     maddr;
  logic            mfault;
  logic            ok1, ok2, full;
  logic            ctest;
  logic [63:0]     asum;

  logic            it_start, it_done;
  iter_op_t        it_op;
  logic [63:0]     it_result;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tuser  = oov_r;
  assign out_tdata  = {5'd0, oerr_r, oval_r, onip_r};

  assign dd_m1  = dd_r - DW'(1);
  assign dd_m2  = dd_r - DW'(2);
  assign rd_m1  = rd_r - RDW'(1);
  assign ridx   = opnd_r[RIW-1:0];
  assign badreg = (opnd_r >= 64'(NUM_REGS));
  assign maddr  = regs_r[ridx];
  assign mfault = msel_r ? (maddr >= 64'(VRAM_WORDS)) : (maddr >= 64'(RAM_WORDS));
  assign ok1    = (dd_r != DW'(0));
  assign ok2    = (dd_r >= DW'(2));
  assign full   = (dd_r >= DW'(STACK_DEPTH));
  assign commit = (state_r == ST_RESP) && (!ovalid_r || out_tready);
  assign ds_raddr = (state_r == ST_RD1) ? dd_m1[SW-1:0] : dd_m2[SW-1:0];

  always_comb begin
    case (cond_t'(cond_r))
      C_LT:    ctest = $signed(a_r) <  $signed(b_r);
      C_LE:    ctest = $signed(a_r) <= $signed(b_r);
      C_GT:    ctest = $signed(a_r) >  $signed(b_r);
      C_GE:    ctest = $signed(a_r) >= $signed(b_r);
      C_EQ:    ctest = (a_r == b_r);
      C_NE:    ctest = (a_r != b_r);
      default: ctest = 1'b0;
    endcase
  end

  assign asum = (kind_r == K_SUB) ? (b_r - a_r) : (b_r + a_r);

  always_comb begin
    it_start = 1'b0;
    it_op    = IT_MUL;
    case (kind_r)
      K_MUL: begin
        it_op    = IT_MUL;
        it_start = (state_r == ST_EXEC) && ok2;
      end
      K_DIV: begin
        it_op    = IT_DIV;
        it_start = (state_r == ST_EXEC) && ok2 && (a_r != 64'd0);
      end
      K_SQRT: begin
        it_op    = IT_SQRT;
        it_start = (state_r == ST_EXEC) && ok1 && !a_r[63];
      end
      default: begin
      end
    endcase
  end

  // per-instruction result and write-back
  always_comb begin
    nip       = ip_r + 16'd1;
    err       = ERR_OK;
    ov        = 1'b0;
    oval      = 64'd0;
    dd_nxt    = dd_r;
    rd_nxt    = rd_r;
    ds_we     = 1'b0;
    ds_waddr  = dd_r[SW-1:0];
    ds_wdata  = opnd_r;
    rs_we     = 1'b0;
    reg_we    = 1'b0;
    ram_we    = 1'b0;
    vram_we   = 1'b0;
    case (kind_r)
      K_PUSH: begin
        nip = ip_r + 16'd2;
        if (full) begin
          err = ERR_OVER;
        end else begin
          ds_we  = 1'b1;
          dd_nxt = dd_r + DW'(1);
        end
      end
      K_OUT: begin
        if (!ok1) begin
          err = ERR_UNDER;
        end else begin
          ov     = 1'b1;
          oval   = a_r;
          dd_nxt = dd_m1;
        end
      end
      K_ADD, K_SUB, K_MUL, K_DIV: begin
        if (!ok2) begin
          err = ERR_UNDER;
          nip = ip_r;
        end else if ((kind_r == K_DIV) && (a_r == 64'd0)) begin
          err = ERR_DIVZERO;
          nip = ip_r;
        end else begin
          ds_we    = 1'b1;
          ds_waddr = dd_m2[SW-1:0];
          ds_wdata = ((kind_r == K_ADD) || (kind_r == K_SUB)) ? asum : it_result;
          dd_nxt   = dd_m1;
        end
      end
      K_SQRT: begin
        if (!ok1) begin
          err = ERR_UNDER;
          nip = ip_r;
        end else if (a_r[63]) begin
          err = ERR_SQRTNEG;
          nip = ip_r;
        end else begin
          ds_we    = 1'b1;
          ds_waddr = dd_m1[SW-1:0];
          ds_wdata = it_result;
        end
      end
      K_PUSHR, K_PUSHM: begin
        nip = ip_r + 16'd2;
        ds_wdata = (kind_r == K_PUSHR) ? maddr : mem_r;
        if (badreg) begin
          err = ERR_BADREG;
          nip = ip_r;
        end else if ((kind_r == K_PUSHM) && mfault) begin
          err = msel_r ? ERR_VRAM : ERR_RAM;
          nip = ip_r;
        end else if (full) begin
          err = ERR_OVER;
        end else begin
          ds_we  = 1'b1;
          dd_nxt = dd_r + DW'(1);
        end
      end
      K_POPR, K_POPM: begin
        nip = ip_r + 16'd2;
        if (badreg) begin
          err = ERR_BADREG;
          nip = ip_r;
        end else if ((kind_r == K_POPM) && mfault) begin
          err = msel_r ? ERR_VRAM : ERR_RAM;
          nip = ip_r;
        end else if (!ok1) begin
          err = ERR_UNDER;
        end else begin
          dd_nxt  = dd_m1;
          reg_we  = (kind_r == K_POPR);
          ram_we  = (kind_r == K_POPM) && !msel_r;
          vram_we = (kind_r == K_POPM) && msel_r;
        end
      end
      K_JMP: begin
        nip = opnd_r[15:0];
      end
      K_JCOND: begin
        if (!ok2) begin
          err = ERR_UNDER;
          nip = ip_r;
        end else begin
          dd_nxt = dd_m2;
          nip    = ctest ? opnd_r[15:0] : (ip_r + 16'd2);
        end
      end
      K_CALL: begin
        nip = opnd_r[15:0];
        if (rd_r >= RDW'(RETURN_DEPTH)) begin
          err = ERR_OVER;
        end else begin
          rs_we  = 1'b1;
          rd_nxt = rd_r + RDW'(1);
        end
      end
      K_RET: begin
        if (rd_r == RDW'(0)) begin
          err = ERR_UNDER;
          nip = 16'd0;
        end else begin
          rd_nxt = rd_m1;
          nip    = ret_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_r == CLW'(MEMW - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_tvalid) state_nxt = ST_RD1;
      ST_RD1:   state_nxt = ST_RD2;
      ST_RD2:   state_nxt = ST_RD3;
      ST_RD3:   state_nxt = ST_EXEC;
      ST_EXEC:  state_nxt = it_start ? ST_ITER : ST_RESP;
      ST_ITER:  if (it_done) state_nxt = ST_RESP;
      ST_RESP:  if (commit) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  assign ip_nxt = commit ? nip : ip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      clr_r    <= '0;
      ip_r     <= 16'd0;
      dd_r     <= '0;
      rd_r     <= '0;
      ovalid_r <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_r[i] <= 64'd0;
      end
    end else begin
      state_r <= state_nxt;
      ip_r    <= ip_nxt;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + CLW'(1);
      end
      if (commit) begin
        dd_r     <= dd_nxt;
        rd_r     <= rd_nxt;
        ovalid_r <= 1'b1;
        if (reg_we) begin
          regs_r[ridx] <= a_r;
        end
      end else if (out_tready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      kind_r <= kind_t'(in_tuser[3:0]);
      msel_r <= in_tuser[4];
      opnd_r <= in_tdata[63:0];
      cond_r <= in_tdata[66:64];
    end
    if (state_r == ST_RD2) begin
      a_r   <= ds_rdata;
      ret_r <= rs_rdata;
      mem_r <= msel_r ? vram_rdata : ram_rdata;
    end
    if (state_r == ST_RD3) begin
      b_r <= ds_rdata;
    end
    if (commit) begin
      onip_r <= nip;
      oov_r  <= ov;
      oval_r <= oval;
      oerr_r <= err;
    end
  end

  // memories: clearing pass drives the ram and vram write ports after reset
  always_comb begin
    if (state_r == ST_CLEAR) begin
      ram_waddr  = clr_r[RAW-1:0];
      vram_waddr = clr_r[VAW-1:0];
      ram_wdata  = 64'd0;
      vram_wdata = 64'd0;
    end else begin
      ram_waddr  = maddr[RAW-1:0];
      vram_waddr = maddr[VAW-1:0];
      ram_wdata  = a_r;
      vram_wdata = a_r;
    end
  end

  smx_ram #(.WIDTH(64), .DEPTH(STACK_DEPTH)) u_dstack (
    .clk   (clk),
    .we    (commit && ds_we),
    .waddr (ds_waddr),
    .wdata (ds_wdata),
    .raddr (ds_raddr),
    .rdata (ds_rdata)
  );

  smx_ram #(.WIDTH(16), .DEPTH(RETURN_DEPTH)) u_rstack (
    .clk   (clk),
    .we    (commit && rs_we),
    .waddr (rd_r[RSW-1:0]),
    .wdata (ip_r + 16'd2),
    .raddr (rd_m1[RSW-1:0]),
    .rdata (rs_rdata)
  );

  smx_ram #(.WIDTH(64), .DEPTH(RAM_WORDS)) u_ram (
    .clk   (clk),
    .we    (((state_r == ST_CLEAR) && (clr_r < CLW'(RAM_WORDS))) || (commit && ram_we)),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (maddr[RAW-1:0]),
    .rdata (ram_rdata)
  );

  smx_ram #(.WIDTH(64), .DEPTH(VRAM_WORDS)) u_vram (
    .clk   (clk),
    .we    (((state_r == ST_CLEAR) && (clr_r < CLW'(VRAM_WORDS))) || (commit && vram_we)),
    .waddr (vram_waddr),
    .wdata (vram_wdata),
    .raddr (maddr[VAW-1:0]),
    .rdata (vram_rdata)
  );

  smx_iter u_iter (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (it_start),
    .op     (it_op),
    .a      (a_r),
    .b      (b_r),
    .done   (it_done),
    .result (it_result)
  );

endmodule

`default_nettype wire
